@@ rtl/ctp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctp_pkg: shared types and constants of the code page to UTF-8 transcoder
// Holds the default Central-European code point table, the result status
// codes and the record that passes a converted character to the output stage.
// ----------------------------------------------------------------------------
package ctp_pkg;

	// Number of table entries, one for each byte value from 0x80 up.
	localparam int unsigned TABLE_DEPTH = 128;

	// Widths of the payload fields.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CODE_W  = 16;
	localparam int unsigned INDEX_W = 7;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TOTAL_W = 17;
	localparam int unsigned LIMIT_W = 16;

	// Configuration register indexes.
	localparam logic CFG_OUTPUT_LIMIT = 1'b0;
	localparam logic CFG_COUNT_ONLY   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET = 16'hFFFF;
	localparam logic               COUNT_ONLY_RESET   = 1'b0;

	// Saturation value of the byte count in count-only mode.
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// UTF-8 encoding thresholds and lead/continuation marks.
	localparam logic [CODE_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
	localparam logic [CODE_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
	localparam logic [BYTE_W-1:0] LEAD2_MARK     = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MARK     = 8'hE0;
	localparam logic [BYTE_W-1:0] CONT_MARK      = 8'h80;

	// Status of a result.
	typedef enum logic [1:0] {
		ST_DATA        = 2'd0,
		ST_END         = 2'd1,
		ST_END_NO_ROOM = 2'd2
	} ctp_status_t;

	// One converted character: up to three bytes, or one end-of-string result.
	typedef struct packed {
		logic [2:0][BYTE_W-1:0] bytes;
		logic [1:0]             last_idx;
		ctp_status_t            status;
		logic                   trunc;
		logic [TOTAL_W-1:0]     total;
	} ctp_res_t;

	// Default Central-European code points for bytes 0x80 to 0xFF.
	localparam logic [CODE_W-1:0] DEFAULT_CODES [TABLE_DEPTH] = '{
		16'h20AC, 16'h002E, 16'h201A, 16'h002E, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h002E, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
		16'h002E, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h002E, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A,
		16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
		16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
		16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
		16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C,
		16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
		16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
		16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
		16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
		16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
		16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
		16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
		16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
	};

endpackage

@@ rtl/ctp_table.sv @@
// ----------------------------------------------------------------------------
// ctp_table: code point table
// A synchronous single-port-write, single-port-read memory with one valid bit
// per entry. An entry that was never rewritten reads as its default value.
// ----------------------------------------------------------------------------
module ctp_table #(
	parameter int unsigned TableDepth = ctp_pkg::TABLE_DEPTH,
	localparam int unsigned IdxW = $clog2(TableDepth)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [IdxW-1:0]             waddr,
	input  logic [ctp_pkg::CODE_W-1:0]  wdata,
	input  logic                        re,
	input  logic [IdxW-1:0]             raddr,
	output logic [ctp_pkg::CODE_W-1:0]  rcode
);

	logic [ctp_pkg::CODE_W-1:0] mem [TableDepth];
	logic [TableDepth-1:0]      written_q;
	logic [ctp_pkg::CODE_W-1:0] rdata_q;
	logic                       rvalid_q;
	logic [IdxW-1:0]            raddr_q;

	// Memory write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
			raddr_q <= raddr;
		end
	end

	// Valid bits: cleared by reset, set by the first write to an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= written_q[raddr];
			end
		end
	end

	// An entry not yet written falls back to the default table.
	assign rcode = rvalid_q ? rdata_q : ctp_pkg::DEFAULT_CODES[raddr_q];

endmodule

@@ rtl/ctp_encode.sv @@
// ----------------------------------------------------------------------------
// ctp_encode: conversion stage
// Holds one text byte with its table read, keeps the running byte count and
// the stopped flag, and forms the UTF-8 bytes or the end-of-string result.
// ----------------------------------------------------------------------------
module ctp_encode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [ctp_pkg::BYTE_W-1:0]   load_byte,
	input  logic [ctp_pkg::CODE_W-1:0]   tbl_code,
	input  logic [ctp_pkg::LIMIT_W-1:0]  output_limit,
	input  logic                         count_only,
	output logic                         in_ready,
	output logic                         res_valid,
	output ctp_pkg::ctp_res_t            res,
	input  logic                         res_ready
);

	logic                          valid_s1;
	logic [ctp_pkg::BYTE_W-1:0]    byte_s1;
	logic [ctp_pkg::COUNT_W-1:0]   count_q;
	logic                          stopped_q;

	logic [ctp_pkg::CODE_W-1:0]    cp;
	logic [2:0][ctp_pkg::BYTE_W-1:0] enc_bytes;
	logic [1:0]                    nbytes;
	logic [ctp_pkg::COUNT_W:0]     sum;
	logic [ctp_pkg::TOTAL_W-1:0]   count_plus1;
	logic                          is_end;
	logic                          fits;
	logic                          has_res;
	logic                          adv;

	// Code point of the held byte and its UTF-8 form.
	always_comb begin
		cp = byte_s1[ctp_pkg::BYTE_W-1] ? tbl_code
			: {{(ctp_pkg::CODE_W-ctp_pkg::BYTE_W){1'b0}}, byte_s1};
		enc_bytes = '0;
		if (cp < ctp_pkg::ONE_BYTE_LIMIT) begin
			nbytes       = 2'd1;
			enc_bytes[0] = cp[7:0];
		end else if (cp < ctp_pkg::TWO_BYTE_LIMIT) begin
			nbytes       = 2'd2;
			enc_bytes[0] = ctp_pkg::LEAD2_MARK | {3'b000, cp[10:6]};
			enc_bytes[1] = ctp_pkg::CONT_MARK | {2'b00, cp[5:0]};
		end else begin
			nbytes       = 2'd3;
			enc_bytes[0] = ctp_pkg::LEAD3_MARK | {4'h0, cp[15:12]};
			enc_bytes[1] = ctp_pkg::CONT_MARK | {2'b00, cp[11:6]};
			enc_bytes[2] = ctp_pkg::CONT_MARK | {2'b00, cp[5:0]};
		end
	end

	// Room check and the result record.
	always_comb begin
		sum         = {1'b0, count_q} + {{(ctp_pkg::COUNT_W-1){1'b0}}, nbytes};
		count_plus1 = {1'b0, count_q} + {{(ctp_pkg::TOTAL_W-1){1'b0}}, 1'b1};
		fits        = sum <= {1'b0, output_limit};
		is_end      = byte_s1 == '0;
		has_res     = is_end || (!stopped_q && !count_only && fits);

		res.bytes    = enc_bytes;
		res.trunc    = 1'b0;
		res.total    = '0;
		res.status   = ctp_pkg::ST_DATA;
		res.last_idx = nbytes - 2'd1;
		if (is_end) begin
			res.bytes    = '0;
			res.last_idx = 2'd0;
			res.trunc    = stopped_q;
			if (count_only || count_q < output_limit) begin
				res.status = ctp_pkg::ST_END;
				res.total  = count_plus1;
			end else begin
				res.status = ctp_pkg::ST_END_NO_ROOM;
			end
		end
	end

	assign adv       = valid_s1 && (!has_res || res_ready);
	assign in_ready  = !valid_s1 || adv;
	assign res_valid = valid_s1 && has_res;

	// Stage register for the held byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= load_byte;
		end
	end

	// String state: running count and stopped flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else if (adv) begin
			if (is_end) begin
				count_q   <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (count_only) begin
					count_q <= sum[ctp_pkg::COUNT_W] ? ctp_pkg::COUNT_MAX
						: sum[ctp_pkg::COUNT_W-1:0];
				end else if (!fits) begin
					stopped_q <= 1'b1;
				end else begin
					count_q <= sum[ctp_pkg::COUNT_W-1:0];
				end
			end
		end
	end

endmodule

@@ rtl/ctp_serializer.sv @@
// ----------------------------------------------------------------------------
// ctp_serializer: output stage
// Holds one converted character and sends its bytes one per request on the
// output stream, taking the next character as the last byte leaves.
// ----------------------------------------------------------------------------
module ctp_serializer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         res_valid,
	input  ctp_pkg::ctp_res_t            res,
	output logic                         res_ready,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [31:0]                  m_axis_tdata,
	output logic [1:0]                   m_axis_tuser,
	output logic                         m_axis_tlast
);

	logic               valid_s2;
	ctp_pkg::ctp_res_t  res_s2;
	logic [1:0]         ptr_q;
	logic               at_last;

	assign at_last   = ptr_q == res_s2.last_idx;
	assign res_ready = !valid_s2 || (m_axis_tready && at_last);

	// Beat pointer and valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ptr_q    <= '0;
		end else if (res_valid && res_ready) begin
			valid_s2 <= 1'b1;
			ptr_q    <= '0;
		end else if (valid_s2 && m_axis_tready) begin
			if (at_last) begin
				valid_s2 <= 1'b0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, res_s2.total, res_s2.trunc, res_s2.bytes[ptr_q]};
	assign m_axis_tuser  = res_s2.status;
	assign m_axis_tlast  = at_last;

endmodule

@@ rtl/codepage_to_utf8_transcoder.sv @@
// ----------------------------------------------------------------------------
// codepage_to_utf8_transcoder: single-byte code page to UTF-8 converter
// Converts text bytes to UTF-8 through a rewritable 128-entry code point
// table and reports the string length at each zero terminator.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries text bytes (tuser 0) or table writes (tuser 1).
// Each non-zero text byte gives 1 to 3 output bytes while they fit in
// output_limit; after the first character that does not fit, the rest of the
// string is dropped. A zero byte gives one end result with the status, the
// truncation flag and the total length, and restarts the count. Table writes
// and dropped bytes give no output, nor do text bytes in count_only mode.
// A byte is held in the conversion stage register and its result in the
// output stage register before the first result is presented on the output.
// The input takes a request every cycle while the output drains and no
// character has more than one UTF-8 byte; a character leaves as one output
// beat per UTF-8 byte (1 to 3).
// The configuration port is always ready; write it only while idle.
// Reset restores the default table (per-entry valid bits clear at once),
// output_limit 65535 and count_only 0. When the receiver stalls, the output
// holds its result and the input stops after one more character is held.
// ----------------------------------------------------------------------------
module codepage_to_utf8_transcoder #(
	parameter int unsigned TableDepth = ctp_pkg::TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // text_byte[7:0], entry_index[14:8],
	                                   // entry_code_point[30:15], zero[31]
	input  logic        s_axis_tuser,  // mode[0]
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_byte[7:0], was_truncated[8],
	                                   // total_length[25:9], zero[31:26]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	output logic        m_axis_tlast,  // last
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned IdxW = $clog2(TableDepth);

	logic                          accept;
	logic                          tbl_we;
	logic                          tbl_re;
	logic [ctp_pkg::CODE_W-1:0]    tbl_code;
	logic [ctp_pkg::LIMIT_W-1:0]   output_limit_q;
	logic                          count_only_q;
	logic                          res_valid;
	logic                          res_ready;
	ctp_pkg::ctp_res_t             res;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign tbl_we = accept && s_axis_tuser;
	assign tbl_re = accept && !s_axis_tuser;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= ctp_pkg::OUTPUT_LIMIT_RESET;
			count_only_q   <= ctp_pkg::COUNT_ONLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ctp_pkg::CFG_OUTPUT_LIMIT: output_limit_q <= cfg_data;
				ctp_pkg::CFG_COUNT_ONLY:   count_only_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Code point table.
	ctp_table #(
		.TableDepth(TableDepth)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tbl_we),
		.waddr (s_axis_tdata[8 +: IdxW]),
		.wdata (s_axis_tdata[30:15]),
		.re    (tbl_re),
		.raddr (s_axis_tdata[IdxW-1:0]),
		.rcode (tbl_code)
	);

	// Conversion stage.
	ctp_encode u_encode (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (tbl_re),
		.load_byte   (s_axis_tdata[7:0]),
		.tbl_code    (tbl_code),
		.output_limit(output_limit_q),
		.count_only  (count_only_q),
		.in_ready    (s_axis_tready),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	// Output stage.
	ctp_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

@@ rtl/ctp_checker.sv @@
// ----------------------------------------------------------------------------
// ctp_checker: output stream checks for the transcoder
// Watches the output ports and checks the handshake and the consistency of
// status, length and last-item marks.
// ----------------------------------------------------------------------------
module ctp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled request keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
	else $error("output request changed while stalled");

	// An end-of-string result is always the last of its character.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ctp_pkg::ST_DATA |-> m_axis_tlast)
	else $error("end result without last mark");

	// Data bytes carry no length and no truncation flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ctp_pkg::ST_DATA |->
			m_axis_tdata[25:8] == '0)
	else $error("data byte with length or truncation set");

	// Without room for the terminator the length is zero; otherwise it is not.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ctp_pkg::ST_DATA |->
			((m_axis_tuser == ctp_pkg::ST_END_NO_ROOM) == (m_axis_tdata[25:9] == '0))
			&& m_axis_tdata[7:0] == '0)
	else $error("end result length inconsistent with status");

endmodule

bind codepage_to_utf8_transcoder ctp_checker u_ctp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

@@ verif/tb_codepage_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_codepage_to_utf8_transcoder: self-checking bench of the UTF-8 transcoder
// Drives text bytes and table writes through the input stream and keeps its
// own model of the code table, the running string length and the cut-off.
// Each output beat is checked against the oldest predicted result. Directed
// tests cover encoding widths, the output limit and count-only mode. Random
// strings then run under several settings while both streams idle at random.
// ----------------------------------------------------------------------------
module tb_codepage_to_utf8_transcoder;

	localparam logic MODE_TEXT  = 1'b0;
	localparam logic MODE_TABLE = 1'b1;

	localparam int          DRAIN_CYCLES = 10;
	localparam int          CYCLE_LIMIT  = 600000;
	localparam int unsigned SAT_LEN      = 65535;

	// Power-on contents of the code table, bytes 0x80 to 0xFF.
	localparam logic [15:0] DEFAULT_CODE_POINTS [128] = '{
		16'h20AC, 16'h002E, 16'h201A, 16'h002E, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h002E, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
		16'h002E, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h002E, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A,
		16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
		16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
		16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
		16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C,
		16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
		16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
		16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
		16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
		16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
		16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
		16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
		16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
	};

	// One output beat as the transcoder should produce it.
	typedef struct {
		logic [7:0]           data;
		ctp_pkg::ctp_status_t status;
		logic                 trunc;
		logic [16:0]          total;
		logic                 last;
	} utf8_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;  // text_byte[7:0], entry_index[14:8],
	                                  // entry_code_point[30:15], zero[31]
	logic        s_axis_tuser  = 1'b0;  // mode[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // out_byte[7:0], was_truncated[8],
	                            // total_length[25:9], zero[31:26]
	logic [1:0]  m_axis_tuser;  // status[1:0]
	logic        m_axis_tlast;  // last
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_index     = ctp_pkg::CFG_OUTPUT_LIMIT;
	logic [15:0] cfg_data      = '0;

	// Model state: code table, string progress and register copies.
	logic [15:0]  code_tab [128] = DEFAULT_CODE_POINTS;
	int unsigned  str_len        = 0;
	bit           str_cut        = 1'b0;
	logic [15:0]  out_limit      = 16'hFFFF;
	bit           cnt_only       = 1'b0;

	utf8_result_t utf8_due [$];
	int           fail_count  = 0;
	int           cycle_count = 0;
	bit           no_idle     = 1'b0;

	codepage_to_utf8_transcoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(1, 127));
	endfunction

	// Code points spread over one-, two- and three-byte encodings.
	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'($urandom_range(1, 16'h007F));
			2: return 16'($urandom_range(16'h0080, 16'h07FF));
			3: return 16'($urandom_range(16'hD800, 16'hDFFF));
			4: return 16'($urandom_range(16'h0800, 16'hFFFF));
			default: return 16'($urandom);
		endcase
	endfunction

	// Apply one accepted request to the model and queue the beats it causes.
	task automatic transcode_item(input logic mode, input logic [7:0] ch,
	                              input logic [6:0] idx, input logic [15:0] cp_in);
		logic [15:0]  cp;
		logic [7:0]   enc [3];
		int           n;
		utf8_result_t r;
		if (mode == MODE_TABLE) begin
			code_tab[idx] = cp_in;
		end else if (ch == 8'h00) begin
			// End of string: one beat with the length and the cut-off flag.
			r.data  = 8'h00;
			r.trunc = str_cut;
			r.last  = 1'b1;
			if (!cnt_only && str_len >= out_limit) begin
				r.status = ctp_pkg::ST_END_NO_ROOM;
				r.total  = '0;
			end else begin
				r.status = ctp_pkg::ST_END;
				r.total  = 17'(str_len + 1);
			end
			utf8_due.push_back(r);
			str_len = 0;
			str_cut = 1'b0;
		end else if (!str_cut) begin
			cp = ch[7] ? code_tab[ch[6:0]] : {8'h00, ch};
			if (cp < 16'h0080) begin
				n      = 1;
				enc[0] = cp[7:0];
			end else if (cp < 16'h0800) begin
				n      = 2;
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end else begin
				n      = 3;
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			if (cnt_only) begin
				str_len = str_len + n;
				if (str_len > SAT_LEN)
					str_len = SAT_LEN;
			end else if (str_len + n > out_limit) begin
				str_cut = 1'b1;
			end else begin
				str_len = str_len + n;
				for (int k = 0; k < n; k++) begin
					r.data   = enc[k];
					r.status = ctp_pkg::ST_DATA;
					r.trunc  = 1'b0;
					r.total  = '0;
					r.last   = (k == n - 1);
					utf8_due.push_back(r);
				end
			end
		end
	endtask

	// Offer one request after a random gap and model it once it is taken.
	task automatic send_item(input logic mode, input logic [7:0] ch,
	                         input logic [6:0] idx, input logic [15:0] cp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {1'b0, cp, idx, ch};
		do @(posedge clk); while (!s_axis_tready);
		transcode_item(mode, ch, idx, cp);
	endtask

	task automatic send_text(input logic [7:0] ch);
		send_item(MODE_TEXT, ch, 7'($urandom), 16'($urandom));
	endtask

	task automatic send_entry(input logic [6:0] idx, input logic [15:0] cp);
		send_item(MODE_TABLE, 8'($urandom), idx, cp);
	endtask

	// Hold off the input until every predicted beat is out and the pipe is empty.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (utf8_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [15:0] value);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == ctp_pkg::CFG_OUTPUT_LIMIT)
			out_limit = value;
		else
			cnt_only = value[0];
	endtask

	// Reset settings: one, two and three byte characters, code point zero,
	// a surrogate and the top code point from rewritten entries.
	task automatic test_encoding();
		send_text(8'h41);
		send_text(8'h7F);
		send_text(8'h80);
		send_text(8'hA3);
		send_text(8'hFF);
		send_entry(7'h05, 16'h0000);
		send_entry(7'h06, 16'hD800);
		send_entry(7'h7F, 16'hFFFF);
		send_text(8'h85);
		send_text(8'h86);
		send_text(8'hFF);
		send_text(8'h00);
	endtask

	// Exact fit, cut-off with later bytes dropped, missing terminator room.
	task automatic test_output_limit();
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'd5);
		send_text(8'h80);
		send_text(8'h41);
		send_text(8'h00);
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'd4);
		send_text(8'h80);
		send_text(8'h41);
		send_text(8'h42);
		send_text(8'h43);
		send_text(8'h00);
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'd0);
		send_text(8'h00);
		send_text(8'h41);
		send_text(8'h00);
	endtask

	// A string cut before count-only mode stays cut; then a plain count.
	task automatic test_count_only();
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'd2);
		send_text(8'h80);
		write_reg(ctp_pkg::CFG_COUNT_ONLY, 16'd1);
		send_text(8'h41);
		send_text(8'h00);
		send_text(8'h80);
		send_text(8'h41);
		send_text(8'h00);
	endtask

	// Mostly terminated strings, with table writes and stray bytes mixed in.
	task automatic run_strings(input int n_items);
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_entry(7'($urandom), pick_code());
				sent++;
			end else if (r < 16) begin
				send_text(8'($urandom));
				sent++;
			end else begin
				len = $urandom_range(0, 10);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 19) == 0)
						send_entry(7'($urandom), pick_code());
					send_text(pick_char());
				end
				send_text(8'h00);
				sent += len + 1;
			end
		end
	endtask

	task automatic test_random_traffic();
		write_reg(ctp_pkg::CFG_COUNT_ONLY, 16'd0);
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'hFFFF);
		run_strings(45);
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'($urandom_range(4, 24)));
		run_strings(55);
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'($urandom_range(0, 3)));
		run_strings(20);
		write_reg(ctp_pkg::CFG_COUNT_ONLY, 16'd1);
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'($urandom));
		run_strings(30);
		// Back-to-back stretch with no gaps on the input side.
		write_reg(ctp_pkg::CFG_COUNT_ONLY, 16'd0);
		write_reg(ctp_pkg::CFG_OUTPUT_LIMIT, 16'd40);
		no_idle = 1'b1;
		run_strings(20);
		no_idle = 1'b0;
	endtask

	// Main sequence.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encoding();
		test_output_limit();
		test_count_only();
		test_random_traffic();
		wait_quiet();
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Output back-pressure: ready runs broken by random stalls.
	initial begin : sink_pacing
		int run_len;
		int hold;
		forever begin
			run_len = $urandom_range(1, 24);
			m_axis_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	task automatic flag_mismatch(input string field, input logic [16:0] want,
	                             input logic [16:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		fail_count++;
	endtask

	// Compare each accepted output beat with the oldest predicted one.
	always @(posedge clk) begin : check_output
		utf8_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (utf8_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual byte %02h status %0d",
				         $time, m_axis_tdata[7:0], m_axis_tuser);
				fail_count++;
			end else begin
				want = utf8_due.pop_front();
				if (m_axis_tdata[7:0] !== want.data)
					flag_mismatch("out_byte", 17'(want.data), 17'(m_axis_tdata[7:0]));
				if (m_axis_tuser !== want.status)
					flag_mismatch("status", 17'(want.status), 17'(m_axis_tuser));
				if (m_axis_tdata[8] !== want.trunc)
					flag_mismatch("was_truncated", 17'(want.trunc), 17'(m_axis_tdata[8]));
				if (m_axis_tdata[25:9] !== want.total)
					flag_mismatch("total_length", want.total, m_axis_tdata[25:9]);
				if (m_axis_tlast !== want.last)
					flag_mismatch("last", 17'(want.last), 17'(m_axis_tlast));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results still due", $time, utf8_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

@@ files.f @@
rtl/ctp_pkg.sv
rtl/ctp_table.sv
rtl/ctp_encode.sv
rtl/ctp_serializer.sv
rtl/codepage_to_utf8_transcoder.sv
rtl/ctp_checker.sv
verif/tb_codepage_to_utf8_transcoder.sv
